// ===== design/sortable_key_encoder_macros.svh =====
// assertion macros for the sortable key encoder
`ifndef SORTABLE_KEY_ENCODER_MACROS_SVH
`define SORTABLE_KEY_ENCODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SKE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SKE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ske_pkg.sv =====
// shared types, constants and helper functions of the sortable key encoder
`default_nettype none

package ske_pkg;

	localparam int MAX_PARTS      = 6;
	localparam int MAX_PART_BYTES = 64;
	localparam int CFG_INDEX_W    = 3;
	localparam int CFG_DATA_W     = 11;

	typedef logic [2:0]  part_idx_t;
	typedef logic [6:0]  width_t;
	typedef logic [10:0] layout_t;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_PART_COUNT   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PART0_LAYOUT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PART1_LAYOUT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PART2_LAYOUT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_PART3_LAYOUT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_PART4_LAYOUT = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_PART5_LAYOUT = 3'd6;

	typedef enum logic [2:0] {
		KIND_CHAR     = 3'd0,
		KIND_WIDE     = 3'd1,
		KIND_INT      = 3'd2,
		KIND_DOUBLE   = 3'd3,
		KIND_DATE     = 3'd4,
		KIND_DATETIME = 3'd5,
		KIND_BOOL     = 3'd6,
		KIND_BINARY   = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_PAD,
		ST_CLOSE,
		ST_FIN_INIT,
		ST_FIN,
		ST_FLUSH
	} ctrl_state_t;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic accept;
		logic step;
		logic pad;
		logic close;
		logic fin_init;
		logic fin_step;
		logic flush;
	} ske_cmd_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic busy;
		logic full_word;
		logic emit_ok;
		logic out_free;
		logic last_part;
		logic bip_zero;
		logic fin_end;
		logic hold_valid;
		logic close_req;
		logic fin_req;
	} ske_sts_t;

	// byte width of a part from its layout
	function automatic width_t width_of(input layout_t lay);
		width_t w;
		w = lay[10:4];
		if (w > width_t'(MAX_PART_BYTES)) w = width_t'(MAX_PART_BYTES);
		if (w == '0) w = 7'd1;
		case (kind_t'(lay[2:0])) inside
			KIND_INT, KIND_DATE:         w = 7'd4;
			KIND_DOUBLE, KIND_DATETIME:  w = 7'd8;
			KIND_BOOL:                   w = 7'd1;
			default:                     w = w;
		endcase
		return w;
	endfunction

	// part count clamped to 1..MAX_PARTS
	function automatic part_idx_t eff_count(input part_idx_t pc);
		part_idx_t c;
		c = pc;
		if (c == '0) c = 3'd1;
		if (c > part_idx_t'(MAX_PARTS)) c = part_idx_t'(MAX_PARTS);
		return c;
	endfunction

	// parts past the last layout register read the last one
	function automatic part_idx_t part_sel(input part_idx_t p);
		return (p > part_idx_t'(MAX_PARTS - 1)) ? part_idx_t'(MAX_PARTS - 1) : p;
	endfunction

endpackage

`default_nettype wire

// ===== design/sortable_key_encoder.sv =====
// top level of the sortable key encoder: config, sequencer, datapath
//
// usage
//   cfg_we/cfg_index/cfg_data write part_count (index 0) and the six part
//   layouts (index 1..6), only while the block is idle
//   the slave stream takes one element or scalar per transaction; the master
//   stream returns the key as words of up to eight bytes, first byte in the
//   top bits, with part_done, key_done and the sticky truncation flag
//   tlast on the master side marks the last word caused by one input item
// sequence
//   one item at a time: accept, fill and release, plus pad and close when the
//   part closes and a zero-fill start for a zero fill, with the byte-packer steps
//   (up to 8 bytes each, so padding a 64 byte part takes up to 8 steps) and the
//   zero-fill steps, each writing one word; each word passes from the packer
//   through the hold slot into the output register
// reset
//   arst_n clears the key state, part_count goes to 1, layouts to 0
// stalls
//   while m_tready is low, words wait in the output register and the hold
//   slot; the sequencer stops and s_tready stays low until the item is done
`default_nettype none

`include "sortable_key_encoder_macros.svh"

module sortable_key_encoder
	import ske_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// input items
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [63:0]            s_tdata,  // [63:0] value
	input  wire logic [1:0]             s_tuser,  // [0] element_valid, [1] finish_key
	input  wire logic                   s_tlast,  // end_of_part
	// key words
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [71:0]                 m_tdata,  // [63:0] key_word, [67:64] byte_count, rest 0
	output logic [2:0]                  m_tuser,  // [0] part_done, [1] key_done, [2] truncated
	output logic                        m_tlast   // last_of_run
);

	part_idx_t               part_count;
	layout_t [MAX_PARTS-1:0] layouts;
	ske_cmd_t                cmd;
	ske_sts_t                sts;
	logic [63:0]             out_word;
	logic [3:0]              out_count;
	logic                    out_pd, out_kd, out_trunc;

	// register file, to be written by the user only between items; the block itself does not enforce this
	ske_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.part_count (part_count),
		.layouts    (layouts)
	);

	// sequencer: accept, pack, pad, close, zero-fill, release last word
	ske_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath with the hold slot that learns which word ends the run
	ske_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.part_count (part_count),
		.layouts    (layouts),
		.in_value   (s_tdata),
		.in_valid   (s_tuser[0]),
		.in_eop     (s_tlast),
		.in_fin     (s_tuser[1]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_word   (out_word),
		.out_count  (out_count),
		.out_pd     (out_pd),
		.out_kd     (out_kd),
		.out_trunc  (out_trunc),
		.out_last   (m_tlast)
	);

	assign m_tdata = {4'd0, out_count, out_word};
	assign m_tuser = {out_trunc, out_kd, out_pd};

	// an idle block has released every word of the previous item
	`SKE_ASSERT_IMP(a_idle_hold_empty, s_tready, !sts.hold_valid, "hold slot busy while idle")
	// a word is only produced when the hold slot can take it
	`SKE_ASSERT_IMP(a_emit_room, cmd.close || cmd.fin_step, sts.emit_ok, "word emitted without room")
	// every word carries one to eight bytes
	`SKE_ASSERT_IMP(a_byte_count, m_tvalid, (out_count != 4'd0) && (out_count <= 4'd8), "bad byte count")
	// the key end is also a part end
	`SKE_ASSERT_IMP(a_key_part, m_tvalid && m_tuser[1], m_tuser[0], "key_done without part_done")
	// releasing the held word closes the run
	`SKE_ASSERT_NEXT(a_flush_last, cmd.flush && sts.hold_valid, m_tvalid && m_tlast, "run end lost")

endmodule

`default_nettype wire

// ===== design/ske_cfg.sv =====
// configuration registers: part count and per-part layouts
`default_nettype none

module ske_cfg
	import ske_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [CFG_DATA_W-1:0]       cfg_data,
	output part_idx_t                        part_count,
	output layout_t   [MAX_PARTS-1:0]        layouts
);

	part_idx_t                 part_count_q;
	layout_t   [MAX_PARTS-1:0] layouts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_count_q <= 3'd1;
			layouts_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PART_COUNT:   part_count_q <= cfg_data[2:0];
				REG_PART0_LAYOUT: layouts_q[0] <= cfg_data;
				REG_PART1_LAYOUT: layouts_q[1] <= cfg_data;
				REG_PART2_LAYOUT: layouts_q[2] <= cfg_data;
				REG_PART3_LAYOUT: layouts_q[3] <= cfg_data;
				REG_PART4_LAYOUT: layouts_q[4] <= cfg_data;
				REG_PART5_LAYOUT: layouts_q[5] <= cfg_data;
				default:          part_count_q <= part_count_q;
			endcase
		end
	end

	assign part_count = part_count_q;
	assign layouts    = layouts_q;

endmodule

`default_nettype wire

// ===== design/ske_ctrl.sv =====
// sequencer state machine of the sortable key encoder
`default_nettype none

module ske_ctrl
	import ske_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  ske_sts_t  sts,
	output ske_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_FILL;
				end
			end
			ST_FILL: begin
				if (sts.busy) begin
					cmd.step = !sts.full_word || sts.emit_ok;
				end else if (sts.close_req) begin
					state_d = ST_PAD;
				end else if (sts.fin_req && sts.bip_zero) begin
					state_d = ST_FIN_INIT;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_PAD: begin
				cmd.pad = 1'b1;
				if (sts.busy) begin
					cmd.step = !sts.full_word || sts.emit_ok;
				end else begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (sts.emit_ok) begin
					cmd.close = 1'b1;
					state_d   = (sts.fin_req && !sts.last_part) ? ST_FIN_INIT : ST_FLUSH;
				end
			end
			ST_FIN_INIT: begin
				cmd.fin_init = 1'b1;
				state_d      = ST_FIN;
			end
			ST_FIN: begin
				if (sts.emit_ok) begin
					cmd.fin_step = 1'b1;
					if (sts.fin_end) state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!sts.hold_valid) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/ske_dp.sv =====
// datapath: item decode, byte packer, zero-fill counter and output stage
`default_nettype none

module ske_dp
	import ske_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  ske_cmd_t                   cmd,
	output ske_sts_t                   sts,
	input  part_idx_t                  part_count,
	input  layout_t [MAX_PARTS-1:0]    layouts,
	input  wire logic [63:0]           in_value,
	input  wire logic                  in_valid,
	input  wire logic                  in_eop,
	input  wire logic                  in_fin,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [63:0]                out_word,
	output logic [3:0]                 out_count,
	output logic                       out_pd,
	output logic                       out_kd,
	output logic                       out_trunc,
	output logic                       out_last
);

	// key state
	part_idx_t   cp_q;
	width_t      bip_q;
	logic [3:0]  biw_q;
	logic [63:0] acc_q;
	logic        trunc_q;

	// per-item registers
	logic [63:0] src_q;
	width_t      rem_q;
	width_t      w_q;
	logic        inv_q;
	logic        close_q;
	logic        fin_q;

	// zero-fill counters
	part_idx_t   fin_part_q;
	part_idx_t   fin_last_q;
	width_t      fin_rem_q;

	// hold slot and output register
	logic        hold_v_q;
	logic [63:0] hold_word_q;
	logic [3:0]  hold_count_q;
	logic        hold_pd_q, hold_kd_q, hold_trunc_q;
	logic        out_v_q;
	logic [63:0] out_word_q;
	logic [3:0]  out_count_q;
	logic        out_pd_q, out_kd_q, out_trunc_q, out_last_q;

	// decode of the current part
	layout_t     lay_cur;
	kind_t       kind;
	width_t      w_cur;
	width_t      avail;
	part_idx_t   cnt;
	logic        last_part;
	logic [63:0] src_raw;
	logic [3:0]  n_bytes;
	logic        scalar;
	logic        trunc_set;
	width_t      rem_load;

	assign lay_cur   = layouts[part_sel(cp_q)];
	assign kind      = kind_t'(lay_cur[2:0]);
	assign w_cur     = width_of(lay_cur);
	assign avail     = (bip_q < w_cur) ? w_cur - bip_q : '0;
	assign cnt       = eff_count(part_count);
	assign last_part = ({1'b0, cp_q} + 4'd1) >= {1'b0, cnt};

	always_comb begin
		src_raw   = '0;
		n_bytes   = '0;
		scalar    = 1'b0;
		trunc_set = 1'b0;
		case (kind)
			KIND_CHAR: begin
				src_raw   = {in_value[7:0], 56'd0};
				n_bytes   = 4'd1;
				trunc_set = bip_q >= w_cur;
			end
			KIND_WIDE: begin
				src_raw = {in_value[15:0], 48'd0};
				// a code unit that does not fit whole is dropped
				if (({1'b0, bip_q} + 8'd2) > {1'b0, w_cur}) begin
					trunc_set = 1'b1;
				end else begin
					n_bytes = 4'd2;
				end
			end
			KIND_BINARY: begin
				src_raw = {in_value[7:0], 56'd0};
				n_bytes = 4'd1;
			end
			KIND_INT: begin
				src_raw = {in_value[31:0] ^ 32'h8000_0000, 32'd0};
				n_bytes = 4'd4;
				scalar  = 1'b1;
			end
			KIND_DOUBLE: begin
				src_raw = in_value[63] ? ~in_value : (in_value | {1'b1, 63'd0});
				n_bytes = 4'd8;
				scalar  = 1'b1;
			end
			KIND_DATE: begin
				src_raw   = {in_value[63:32], 32'd0};
				n_bytes   = 4'd4;
				scalar    = 1'b1;
				trunc_set = |in_value[31:0];
			end
			KIND_DATETIME: begin
				src_raw = in_value;
				n_bytes = 4'd8;
				scalar  = 1'b1;
			end
			KIND_BOOL: begin
				src_raw = {((in_value != 64'd0) ? 8'h02 : 8'h01), 56'd0};
				n_bytes = 4'd1;
				scalar  = 1'b1;
			end
		endcase
		if (!in_valid) begin
			n_bytes   = '0;
			scalar    = 1'b0;
			trunc_set = 1'b0;
		end
	end

	assign rem_load = ({3'd0, n_bytes} < avail) ? {3'd0, n_bytes} : avail;

	// byte packer: up to one word's worth of bytes per step
	width_t      rem_eff;
	logic        full_word;
	logic [2:0]  biw_base;
	logic [3:0]  space;
	logic [3:0]  take;
	logic [63:0] src_eff;
	logic [63:0] keep_mask;
	logic [63:0] placed;
	logic [63:0] acc_step;

	assign rem_eff   = cmd.pad ? ((bip_q < w_q) ? w_q - bip_q : '0) : rem_q;
	assign full_word = biw_q == 4'd8;
	assign biw_base  = full_word ? 3'd0 : biw_q[2:0];
	assign space     = 4'd8 - {1'b0, biw_base};
	assign take      = (rem_eff > {3'd0, space}) ? space : rem_eff[3:0];
	assign src_eff   = cmd.pad ? {64{inv_q}} : src_q;
	assign keep_mask = {64{1'b1}} << {4'd8 - take, 3'b000};
	assign placed    = (src_eff & keep_mask) >> {biw_base, 3'b000};
	assign acc_step  = (full_word ? 64'd0 : acc_q) | placed;

	// zero-fill word
	logic [3:0] fin_c;
	logic       fin_pd;
	logic       fin_end;
	width_t     fin_w_next;
	part_idx_t  fin_last_load;

	assign fin_c         = (fin_rem_q > 7'd8) ? 4'd8 : fin_rem_q[3:0];
	assign fin_pd        = fin_rem_q <= 7'd8;
	assign fin_end       = fin_pd && (fin_part_q == fin_last_q);
	assign fin_w_next    = width_of(layouts[part_sel(fin_part_q + 3'd1)]);
	assign fin_last_load = (cp_q < cnt) ? cnt - 3'd1 : cp_q;

	// emission select
	logic        emit_en;
	logic [63:0] emit_word;
	logic [3:0]  emit_count;
	logic        emit_pd, emit_kd;
	logic        load_out;
	logic        out_free;

	always_comb begin
		emit_word  = acc_q;
		emit_count = 4'd8;
		emit_pd    = 1'b0;
		emit_kd    = 1'b0;
		if (cmd.close) begin
			emit_count = biw_q;
			emit_pd    = 1'b1;
			emit_kd    = last_part;
		end else if (cmd.fin_step) begin
			emit_word  = '0;
			emit_count = fin_c;
			emit_pd    = fin_pd;
			emit_kd    = fin_end;
		end
	end

	assign emit_en  = (cmd.step && full_word) || cmd.close || cmd.fin_step;
	assign load_out = hold_v_q && (emit_en || cmd.flush);
	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q       <= '0;
			bip_q      <= '0;
			biw_q      <= '0;
			acc_q      <= '0;
			trunc_q    <= 1'b0;
			rem_q      <= '0;
			close_q    <= 1'b0;
			fin_q      <= 1'b0;
			fin_part_q <= '0;
			fin_last_q <= '0;
			fin_rem_q  <= '0;
			hold_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cmd.accept) begin
				trunc_q <= trunc_q | trunc_set;
				rem_q   <= rem_load;
				close_q <= in_eop || (in_valid && scalar);
				fin_q   <= in_fin;
			end
			if (cmd.step) begin
				acc_q <= acc_step;
				biw_q <= {1'b0, biw_base} + take;
				bip_q <= bip_q + {3'd0, take};
				if (!cmd.pad) rem_q <= rem_q - {3'd0, take};
			end
			if (cmd.close) begin
				acc_q <= '0;
				biw_q <= '0;
				bip_q <= '0;
				if (last_part) begin
					cp_q    <= '0;
					trunc_q <= 1'b0;
				end else begin
					cp_q <= cp_q + 3'd1;
				end
			end
			if (cmd.fin_init) begin
				fin_part_q <= cp_q;
				fin_last_q <= fin_last_load;
				fin_rem_q  <= w_cur;
			end
			if (cmd.fin_step) begin
				if (fin_end) begin
					acc_q   <= '0;
					biw_q   <= '0;
					cp_q    <= '0;
					trunc_q <= 1'b0;
				end else if (fin_pd) begin
					fin_part_q <= fin_part_q + 3'd1;
					fin_rem_q  <= fin_w_next;
				end else begin
					fin_rem_q <= fin_rem_q - 7'd8;
				end
			end
			if (emit_en) begin
				hold_v_q <= 1'b1;
			end else if (cmd.flush) begin
				hold_v_q <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			src_q <= src_raw ^ {64{lay_cur[3]}};
			w_q   <= w_cur;
			inv_q <= lay_cur[3];
		end else if (cmd.step && !cmd.pad) begin
			src_q <= src_q << {take, 3'b000};
		end
		if (emit_en) begin
			hold_word_q  <= emit_word;
			hold_count_q <= emit_count;
			hold_pd_q    <= emit_pd;
			hold_kd_q    <= emit_kd;
			hold_trunc_q <= trunc_q;
		end
		if (load_out) begin
			out_word_q  <= hold_word_q;
			out_count_q <= hold_count_q;
			out_pd_q    <= hold_pd_q;
			out_kd_q    <= hold_kd_q;
			out_trunc_q <= hold_trunc_q;
			out_last_q  <= cmd.flush;
		end
	end

	always_comb begin
		sts            = '0;
		sts.busy       = rem_eff != '0;
		sts.full_word  = full_word;
		sts.emit_ok    = !hold_v_q || out_free;
		sts.out_free   = out_free;
		sts.last_part  = last_part;
		sts.bip_zero   = bip_q == '0;
		sts.fin_end    = fin_end;
		sts.hold_valid = hold_v_q;
		sts.close_req  = close_q;
		sts.fin_req    = fin_q;
	end

	assign out_valid = out_v_q;
	assign out_word  = out_word_q;
	assign out_count = out_count_q;
	assign out_pd    = out_pd_q;
	assign out_kd    = out_kd_q;
	assign out_trunc = out_trunc_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

// ===== bench/tb_sortable_key_encoder.sv =====
// self-checking testbench of the sortable key encoder with its own key predictor
module tb_sortable_key_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	import ske_pkg::*;

	// one key word as it should leave the master stream
	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        part_done;
		logic        key_done;
		logic        trunc;
		logic        run_last;
	} key_word_t;

	// predictor of the encoder plus the queue of key words it still owes
	class key_word_scoreboard;
		logic [2:0]  part_count_r;
		logic [10:0] layout_r [MAX_PARTS];
		int          cur_part;
		int          part_bytes;
		int          word_bytes;
		logic [63:0] word_acc;
		bit          trunc_flag;
		key_word_t   words_due [$];
		int          errors;

		function new();
			part_count_r = 3'd1;
			foreach (layout_r[i]) layout_r[i] = '0;
			cur_part = 0;
			part_bytes = 0;
			word_bytes = 0;
			word_acc = '0;
			trunc_flag = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PART_COUNT:   part_count_r = data[2:0];
				REG_PART0_LAYOUT: layout_r[0] = data;
				REG_PART1_LAYOUT: layout_r[1] = data;
				REG_PART2_LAYOUT: layout_r[2] = data;
				REG_PART3_LAYOUT: layout_r[3] = data;
				REG_PART4_LAYOUT: layout_r[4] = data;
				REG_PART5_LAYOUT: layout_r[5] = data;
				default: ;
			endcase
		endfunction

		// zero means one, anything above six means six
		function int parts_in_key();
			int c;
			c = part_count_r;
			if (c == 0) c = 1;
			if (c > MAX_PARTS) c = MAX_PARTS;
			return c;
		endfunction

		function logic [10:0] layout_at(int p);
			return layout_r[(p > MAX_PARTS - 1) ? MAX_PARTS - 1 : p];
		endfunction

		// scalars have fixed sizes, strings take the width field clamped to 1..64
		function int part_bytes_of(logic [10:0] lay);
			int w;
			case (kind_t'(lay[2:0]))
				KIND_INT, KIND_DATE:        w = 4;
				KIND_DOUBLE, KIND_DATETIME: w = 8;
				KIND_BOOL:                  w = 1;
				default: begin
					w = lay[10:4];
					if (w > MAX_PART_BYTES) w = MAX_PART_BYTES;
					if (w == 0) w = 1;
				end
			endcase
			return w;
		endfunction

		function void push_word(logic [63:0] word, int n, bit pd, bit kd);
			key_word_t e;
			e.word = word;
			e.nbytes = n[3:0];
			e.part_done = pd;
			e.key_done = kd;
			e.trunc = trunc_flag;
			e.run_last = 0;
			words_due.insert(words_due.size(), e);
		endfunction

		// a full word only goes out once another byte needs room
		function void put_byte(logic [7:0] b, int w, bit inv);
			if (part_bytes >= w) return;
			if (word_bytes >= 8) begin
				push_word(word_acc, 8, 0, 0);
				word_acc = '0;
				word_bytes = 0;
			end
			if (inv) b = ~b;
			word_acc |= 64'(b) << (56 - 8 * word_bytes);
			word_bytes++;
			part_bytes++;
		endfunction

		// pad, flush with part_done, and step to the next part or end the key
		function bit close_part(int w, bit inv);
			bit last;
			last = (cur_part + 1 >= parts_in_key());
			while (part_bytes < w) put_byte(8'h00, w, inv);
			push_word(word_acc, word_bytes, 1, last);
			word_acc = '0;
			word_bytes = 0;
			part_bytes = 0;
			if (last) begin
				cur_part = 0;
				trunc_flag = 0;
			end else begin
				cur_part++;
			end
			return last;
		endfunction

		// accepted input transaction: work out every key word it causes
		function void take_item(logic [63:0] value, bit vld, bit eop, bit fin);
			logic [10:0] lay;
			kind_t       kind;
			bit          inv;
			int          w;
			bit          closing;
			bit          key_ended;
			logic [63:0] s;
			int          n;
			int          first;
			int          cnt;
			int          lastp;
			int          rem;
			int          c;

			lay = layout_at(cur_part);
			kind = kind_t'(lay[2:0]);
			inv = lay[3];
			w = part_bytes_of(lay);
			closing = eop;
			key_ended = 0;
			s = '0;
			n = 0;
			first = words_due.size();

			if (vld) begin
				case (kind)
					KIND_CHAR:
						if (part_bytes >= w) trunc_flag = 1;
						else put_byte(value[7:0], w, inv);
					KIND_WIDE:
						// a code unit goes in whole or not at all
						if (part_bytes + 2 > w) begin
							trunc_flag = 1;
						end else begin
							put_byte(value[15:8], w, inv);
							put_byte(value[7:0], w, inv);
						end
					KIND_BINARY:
						put_byte(value[7:0], w, inv);
					KIND_INT: begin
						s = {value[31:0] ^ 32'h8000_0000, 32'h0};
						n = 4;
					end
					KIND_DOUBLE: begin
						s = value[63] ? ~value : (value | 64'h8000_0000_0000_0000);
						n = 8;
					end
					KIND_DATE: begin
						if (value[31:0] != 0) trunc_flag = 1;
						s = {value[63:32], 32'h0};
						n = 4;
					end
					KIND_DATETIME: begin
						s = value;
						n = 8;
					end
					default: begin
						s = {(value != 0) ? 8'd2 : 8'd1, 56'h0};
						n = 1;
					end
				endcase
				if (!(kind inside {KIND_CHAR, KIND_WIDE, KIND_BINARY})) closing = 1;
				for (int i = 0; i < n; i++) put_byte(s[63 - 8 * i -: 8], w, inv);
			end

			if (closing) key_ended = close_part(w, inv);

			// finish only at a part boundary and only if the key is still open
			if (fin && !key_ended && part_bytes == 0) begin
				cnt = parts_in_key();
				lastp = (cur_part < cnt) ? cnt - 1 : cur_part;
				for (int p = cur_part; p <= lastp && p < MAX_PARTS; p++) begin
					rem = part_bytes_of(layout_at(p));
					while (rem > 0) begin
						c = (rem > 8) ? 8 : rem;
						rem -= c;
						push_word(64'h0, c, rem == 0, rem == 0 && p == lastp);
					end
				end
				word_acc = '0;
				word_bytes = 0;
				cur_part = 0;
				trunc_flag = 0;
			end

			if (words_due.size() > first)
				words_due[words_due.size() - 1].run_last = 1'b1;
		endfunction

		// accepted output transaction against the oldest owed word
		function void match_word(logic [71:0] d, logic [2:0] u, logic l);
			key_word_t e;
			if (words_due.size() == 0) begin
				$error("unexpected key word %h, byte_count %0d", d[63:0], d[67:64]);
				errors++;
				return;
			end
			e = words_due.pop_front();
			if (d[63:0] !== e.word) begin
				$error("key_word: expected %h, got %h", e.word, d[63:0]);
				errors++;
			end
			if (d[67:64] !== e.nbytes) begin
				$error("byte_count: expected %0d, got %0d", e.nbytes, d[67:64]);
				errors++;
			end
			if (u[0] !== e.part_done) begin
				$error("part_done: expected %b, got %b", e.part_done, u[0]);
				errors++;
			end
			if (u[1] !== e.key_done) begin
				$error("key_done: expected %b, got %b", e.key_done, u[1]);
				errors++;
			end
			if (u[2] !== e.trunc) begin
				$error("truncated: expected %b, got %b", e.trunc, u[2]);
				errors++;
			end
			if (l !== e.run_last) begin
				$error("last_of_run: expected %b, got %b", e.run_last, l);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [63:0]            s_tdata   = '0;  // [63:0] value
	logic [1:0]             s_tuser   = '0;  // [0] element_valid, [1] finish_key
	logic                   s_tlast   = 1'b0; // end_of_part
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [71:0]            m_tdata;          // [63:0] key_word, [67:64] byte_count
	logic [2:0]             m_tuser;          // [0] part_done, [1] key_done, [2] truncated
	logic                   m_tlast;          // last_of_run

	key_word_scoreboard sb = new();

	// sender and receiver switch between random idling and back-to-back stretches
	bit tx_calm = 0;
	bit rx_calm = 0;

	sortable_key_encoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// worst case is far below this: 48 words per item, each with the longest receiver stall
	initial begin
		#10ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver: checks every accepted word, then holds tready low for a drawn stall
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid === 1'b1 && m_tready) begin
				sb.match_word(m_tdata, m_tuser, m_tlast);
				if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
				hold = rx_calm ? 0 : $urandom_range(0, 16);
			end else if (hold > 0) begin
				hold--;
			end
			m_tready <= (hold == 0);
		end
	end

	function automatic logic [10:0] mk_layout(kind_t k, bit desc, int w);
		return {7'(w), desc, k};
	endfunction

	// extremes of the signed and float encodings show up often
	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 64'h0;
			1:       return 64'hffff_ffff_ffff_ffff;
			2:       return 64'h8000_0000_0000_0000;
			3:       return 64'h7fff_ffff_ffff_ffff;
			4:       return {$urandom, 32'h0};
			5:       return 64'h0000_0000_8000_0000;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// mostly short parts; now and then the largest widths and the zero width
	function automatic logic [10:0] rand_layout();
		int w;
		case ($urandom_range(0, 9))
			0: w = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 64 : 127);
			1: w = $urandom_range(0, 127);
			default: w = $urandom_range(0, 12);
		endcase
		return mk_layout(kind_t'($urandom_range(0, 7)), $urandom_range(0, 1), w);
	endfunction

	// one input transaction after a drawn gap; tvalid stays high if no gap follows
	task automatic send_item(input logic [63:0] v, input bit vld, input bit eop,
			input bit fin);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= v;
		s_tuser  <= {fin, vld};
		s_tlast  <= eop;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.take_item(v, vld, eop, fin);
	endtask

	// block idle: all owed words out plus room for an item that produced none
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.words_due.size() > 0) @(posedge clk);
		repeat (32) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we    <= 1'b0;
	endtask

	// layouts packed with part 0 in the low 11 bits
	task automatic configure(input int count, input logic [6*CFG_DATA_W-1:0] lays);
		write_reg(REG_PART_COUNT, CFG_DATA_W'(count));
		for (int i = 0; i < MAX_PARTS; i++)
			write_reg(REG_PART0_LAYOUT + CFG_INDEX_W'(i), lays[CFG_DATA_W * i +: CFG_DATA_W]);
	endtask

	// mostly well-formed parts for the predicted current layout, some noise
	task automatic next_random_item(output bit counted);
		logic [10:0] lay;
		kind_t       kind;
		int          w;
		int          stride;
		logic [63:0] v;
		bit          vld;
		bit          eop;
		bit          fin;

		lay = sb.layout_at(sb.cur_part);
		kind = kind_t'(lay[2:0]);
		w = sb.part_bytes_of(lay);
		v = pick_value();
		vld = 1;
		eop = 0;
		fin = 0;
		if ($urandom_range(0, 99) < 12) begin
			vld = $urandom_range(0, 1);
			eop = $urandom_range(0, 1);
			fin = $urandom_range(0, 1);
		end else if (kind inside {KIND_CHAR, KIND_WIDE, KIND_BINARY}) begin
			stride = (kind == KIND_WIDE) ? 2 : 1;
			if (sb.part_bytes == 0 && $urandom_range(0, 9) == 0) begin
				// finish right at a part boundary
				vld = 0;
				fin = 1;
				eop = ($urandom_range(0, 3) == 0);
			end else if ($urandom_range(0, 9) == 0) begin
				// close without data
				vld = 0;
				eop = 1;
				fin = ($urandom_range(0, 4) == 0);
			end else begin
				// close near the width most of the time, otherwise run over it
				if (sb.part_bytes + stride >= w)
					eop = ($urandom_range(0, 3) != 0);
				else
					eop = ($urandom_range(0, (w > 12) ? 11 : 3) == 0);
				fin = ($urandom_range(0, 15) == 0);
			end
		end else begin
			eop = $urandom_range(0, 1);
			fin = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 11) == 0) begin
				vld = 0;
				eop = 1;
			end
		end
		send_item(v, vld, eop, fin);
		counted = vld | eop | fin;
	endtask

	initial begin
		int  items;
		int  phase_len;
		int  phase;
		bit  counted;
		logic [6*CFG_DATA_W-1:0] lays;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset layout: one character part of width one
		send_item(64'hffff_ffff_ffff_ffff, 1, 0, 0);
		// second character does not fit: truncation, then close ends the key
		send_item(64'h41, 1, 1, 0);
		// finish on an empty key: zero fill of the single part
		send_item(64'h0, 0, 0, 1);
		settle();

		// count above the maximum, all-ones layout (descending binary of width 127)
		configure(7, {mk_layout(KIND_BOOL, 1, 0), mk_layout(KIND_DATE, 0, 0),
			mk_layout(KIND_DOUBLE, 0, 0), mk_layout(KIND_INT, 1, 0),
			mk_layout(KIND_WIDE, 0, 3), 11'h7ff});
		send_item(64'h0, 1, 1, 0);                    // one byte, 63 inverted pad bytes
		send_item(64'h1234, 1, 0, 0);                 // wide unit fits
		send_item(64'habcd, 1, 1, 0);                 // odd width: unit dropped, pad kept
		send_item(64'h8000_0000, 1, 0, 0);            // descending integer
		send_item(64'h8000_0000_0000_0000, 1, 0, 0);  // negative zero double
		send_item(64'hffff_ffff_0000_0001, 1, 0, 0);  // date with a low half
		send_item(64'h0, 1, 0, 0);                    // descending false ends the key
		// finish while the part holds bytes is ignored
		send_item(64'h5a, 1, 0, 1);
		// close then finish: the rest fills with plain zeros
		send_item(64'h0, 0, 1, 1);
		// finish from the first part fills the whole key
		send_item(64'h0, 0, 0, 1);
		settle();

		configure(2, {mk_layout(KIND_BOOL, 0, 0), mk_layout(KIND_DATETIME, 0, 0),
			mk_layout(KIND_DOUBLE, 0, 0), mk_layout(KIND_INT, 1, 0),
			mk_layout(KIND_BINARY, 0, 2), mk_layout(KIND_INT, 0, 0)});
		send_item(64'h0, 0, 1, 0);                    // scalar closed with no data
		send_item(64'haa, 1, 0, 0);
		send_item(64'hbb, 1, 0, 0);
		// binary overflow drops silently; finish in the key-ending item is ignored
		send_item(64'hcc, 1, 1, 1);
		send_item(64'h7fff_ffff, 1, 0, 0);
		send_item(64'h11, 1, 0, 0);
		settle();

		// layout changed under a part that already holds a byte
		write_reg(REG_PART1_LAYOUT, mk_layout(KIND_DOUBLE, 0, 0));
		send_item(64'h0123_4567_89ab_cdef, 1, 0, 0);
		settle();

		write_reg(REG_PART_COUNT, CFG_DATA_W'(4));
		send_item(64'h5, 1, 0, 0);
		send_item(64'hffff_ffff_ffff_ffff, 1, 0, 0);
		send_item(64'h0000_0001_0000_0000, 1, 0, 0);
		settle();
		// count shrunk below the current part: finish fills just that part
		write_reg(REG_PART_COUNT, CFG_DATA_W'(2));
		send_item(64'h0, 0, 0, 1);
		send_item(64'h1, 1, 0, 0);
		settle();
		// count shrunk again: the open part becomes the last one
		write_reg(REG_PART_COUNT, CFG_DATA_W'(1));
		send_item(64'h3ff0_0000_0000_0000, 1, 0, 0);
		settle();

		// random phases; configuration may change in the middle of a key
		items = 0;
		phase = 0;
		while (items < 250) begin
			for (int i = 0; i < MAX_PARTS; i++)
				lays[CFG_DATA_W * i +: CFG_DATA_W] = rand_layout();
			configure((phase == 0) ? 0 : $urandom_range(0, 7), lays);
			tx_calm = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(15, 40);
			for (int i = 0; i < phase_len && items < 250; i++) begin
				next_random_item(counted);
				if (counted) items++;
			end
			settle();
			phase++;
		end

		if (sb.errors == 0 && sb.words_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
